// ===== sv/hss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, register indexes, spot styles and tables of the halftone
// spot screen.
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int MAX_CELL = 32;
    localparam int PIPE_LATENCY = 12;

    localparam logic [1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [1:0] REG_DOT_STYLE = 2'd1;
    localparam logic [1:0] REG_SMOOTHING = 2'd2;

    localparam logic [2:0] STYLE_ROUND     = 3'd0;
    localparam logic [2:0] STYLE_LINE      = 3'd1;
    localparam logic [2:0] STYLE_DIAMOND   = 3'd2;
    localparam logic [2:0] STYLE_EUCLIDEAN = 3'd3;
    localparam logic [2:0] STYLE_PS        = 3'd4;

    localparam logic [17:0] ONE_Q16      = 18'd65536;
    localparam logic [17:0] PS_INNER_Q16 = 18'd49152;
    localparam logic [17:0] PS_MID_Q16   = 18'd80609;
    localparam logic [15:0] PS_SLOPE_Q16 = 16'd49807;

    typedef struct packed {
        logic [4:0] cell_col;
        logic [4:0] cell_row;
        logic [7:0] luma;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] grey_level;
        logic [7:0] spot_level;
    } t_pix_out;

    typedef struct packed {
        logic [5:0] cell_size;
        logic [2:0] dot_style;
        logic [7:0] smoothing;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [16:0] ax;
        logic [16:0] ay;
        logic [7:0]  luma;
    } t_norm;

    typedef struct packed {
        logic       valid;
        logic [7:0] spot;
        logic [7:0] luma;
    } t_spot;

    // Floor of 2^24 / n for the effective cell sizes.
    function automatic logic [24:0] cell_recip(input logic [5:0] n);
        logic [24:0] r;
        case (n)
            6'd1:  r = 25'd16777216;
            6'd2:  r = 25'd8388608;
            6'd3:  r = 25'd5592405;
            6'd4:  r = 25'd4194304;
            6'd5:  r = 25'd3355443;
            6'd6:  r = 25'd2796202;
            6'd7:  r = 25'd2396745;
            6'd8:  r = 25'd2097152;
            6'd9:  r = 25'd1864135;
            6'd10: r = 25'd1677721;
            6'd11: r = 25'd1525201;
            6'd12: r = 25'd1398101;
            6'd13: r = 25'd1290555;
            6'd14: r = 25'd1198372;
            6'd15: r = 25'd1118481;
            6'd16: r = 25'd1048576;
            6'd17: r = 25'd986895;
            6'd18: r = 25'd932067;
            6'd19: r = 25'd883011;
            6'd20: r = 25'd838860;
            6'd21: r = 25'd798915;
            6'd22: r = 25'd762600;
            6'd23: r = 25'd729444;
            6'd24: r = 25'd699050;
            6'd25: r = 25'd671088;
            6'd26: r = 25'd645277;
            6'd27: r = 25'd621378;
            6'd28: r = 25'd599186;
            6'd29: r = 25'd578524;
            6'd30: r = 25'd559240;
            6'd31: r = 25'd541200;
            6'd32: r = 25'd524288;
            default: r = 25'd16777216;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/hss_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_normalize
// Clamps the texel position and forms the Q16 magnitudes of the normalised
// coordinates through a reciprocal multiply and a one-step correction.
// ----------------------------------------------------------------------------
module hss_normalize (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hss_pkg::t_pix_in i_pix,
    input  hss_pkg::t_cfg   i_cfg,
    output hss_pkg::t_norm  o_norm
);

    logic [5:0]  n_n;
    logic [5:0]  n_half;
    logic [4:0]  n_col;
    logic [4:0]  n_row;
    logic [5:0]  n_dx;
    logic [5:0]  n_dy;

    logic        r1_valid;
    logic [4:0]  r1_mx;
    logic [4:0]  r1_my;
    logic [24:0] r1_recip;
    logic [5:0]  r1_n;
    logic [7:0]  r1_luma;

    logic [29:0] n_px;
    logic [29:0] n_py;

    logic        r2_valid;
    logic [21:0] r2_qx;
    logic [21:0] r2_qy;
    logic [4:0]  r2_mx;
    logic [4:0]  r2_my;
    logic [5:0]  r2_n;
    logic [7:0]  r2_luma;

    logic [27:0] n_rx;
    logic [27:0] n_ry;
    logic [21:0] n_ax;
    logic [21:0] n_ay;

    hss_pkg::t_norm r3_norm;

    always_comb begin
        if (i_cfg.cell_size == 6'd0) begin
            n_n = 6'd1;
        end else if (i_cfg.cell_size > 6'(hss_pkg::MAX_CELL)) begin
            n_n = 6'(hss_pkg::MAX_CELL);
        end else begin
            n_n = i_cfg.cell_size;
        end
        n_half = n_n >> 1;
        n_col = ({1'b0, i_pix.cell_col} >= n_n) ? 5'(n_n - 6'd1) : i_pix.cell_col;
        n_row = ({1'b0, i_pix.cell_row} >= n_n) ? 5'(n_n - 6'd1) : i_pix.cell_row;
        n_dx = {1'b0, n_col} - n_half;
        n_dy = {1'b0, n_row} - n_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_mx    <= n_dx[5] ? 5'(-n_dx) : n_dx[4:0];
        r1_my    <= n_dy[5] ? 5'(-n_dy) : n_dy[4:0];
        r1_recip <= hss_pkg::cell_recip(n_n);
        r1_n     <= n_n;
        r1_luma  <= i_pix.luma;
    end

    assign n_px = 30'(r1_mx) * 30'(r1_recip);
    assign n_py = 30'(r1_my) * 30'(r1_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_qx   <= n_px[28:7];
        r2_qy   <= n_py[28:7];
        r2_mx   <= r1_mx;
        r2_my   <= r1_my;
        r2_n    <= r1_n;
        r2_luma <= r1_luma;
    end

    always_comb begin
        n_rx = 28'({r2_mx, 17'd0}) - 28'(r2_qx) * 28'(r2_n);
        n_ry = 28'({r2_my, 17'd0}) - 28'(r2_qy) * 28'(r2_n);
        n_ax = (n_rx >= 28'(r2_n)) ? r2_qx + 22'd1 : r2_qx;
        n_ay = (n_ry >= 28'(r2_n)) ? r2_qy + 22'd1 : r2_qy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_norm.valid <= 1'b0;
        end else begin
            r3_norm.valid <= r2_valid;
        end
        r3_norm.ax   <= n_ax[16:0];
        r3_norm.ay   <= n_ay[16:0];
        r3_norm.luma <= r2_luma;
    end

    assign o_norm = r3_norm;

endmodule

// ===== sv/hss_spot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_spot
// Evaluates the selected spot function on the normalised magnitudes and
// scales it to an eight-bit spot level.
// ----------------------------------------------------------------------------
module hss_spot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hss_pkg::t_norm i_norm,
    input  logic [2:0]     i_dot_style,
    output hss_pkg::t_spot o_spot
);

    logic        r4_valid;
    logic [32:0] r4_sqx;
    logic [32:0] r4_sqy;
    logic [32:0] r4_dsqx;
    logic [32:0] r4_dsqy;
    logic [32:0] r4_ps;
    logic [16:0] r4_ax;
    logic [16:0] r4_ay;
    logic [17:0] r4_s;
    logic [7:0]  r4_luma;

    logic [16:0] n_dx;
    logic [16:0] n_dy;
    logic [33:0] n_round;
    logic [33:0] n_outer;
    logic [33:0] n_v;
    logic        n_unknown;

    logic        r5_valid;
    logic [33:0] r5_v;
    logic        r5_unknown;
    logic [7:0]  r5_luma;

    logic [41:0] n_prod;

    hss_pkg::t_spot r6_spot;

    assign n_dx = 17'(hss_pkg::ONE_Q16) - i_norm.ax;
    assign n_dy = 17'(hss_pkg::ONE_Q16) - i_norm.ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= i_norm.valid;
        end
        r4_sqx  <= 33'(i_norm.ax) * 33'(i_norm.ax);
        r4_sqy  <= 33'(i_norm.ay) * 33'(i_norm.ay);
        r4_dsqx <= 33'(n_dx) * 33'(n_dx);
        r4_dsqy <= 33'(n_dy) * 33'(n_dy);
        r4_ps   <= 33'(i_norm.ay) * 33'(hss_pkg::PS_SLOPE_Q16);
        r4_ax   <= i_norm.ax;
        r4_ay   <= i_norm.ay;
        r4_s    <= 18'(i_norm.ax) + 18'(i_norm.ay);
        r4_luma <= i_norm.luma;
    end

    always_comb begin
        n_round   = 34'h2_0000_0000 - (34'(r4_sqx) + 34'(r4_sqy));
        n_outer   = 34'(r4_dsqx) + 34'(r4_dsqy);
        n_unknown = 1'b0;
        n_v       = n_round;
        case (i_dot_style)
            hss_pkg::STYLE_ROUND: begin
                n_v = n_round;
            end
            hss_pkg::STYLE_LINE: begin
                n_v = 34'(17'(hss_pkg::ONE_Q16) - r4_ay) << 17;
            end
            hss_pkg::STYLE_DIAMOND: begin
                n_v = 34'(18'd131072 - r4_s) << 16;
            end
            hss_pkg::STYLE_EUCLIDEAN: begin
                n_v = (r4_s > hss_pkg::ONE_Q16) ? n_outer : n_round;
            end
            hss_pkg::STYLE_PS: begin
                if (r4_s <= hss_pkg::PS_INNER_Q16) begin
                    n_v = n_round;
                end else if (r4_s <= hss_pkg::PS_MID_Q16) begin
                    n_v = 34'h2_0000_0000 - (34'(r4_ps) + (34'(r4_ax) << 16));
                end else begin
                    n_v = n_outer;
                end
            end
            default: begin
                n_unknown = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_v       <= n_v;
        r5_unknown <= n_unknown;
        r5_luma    <= r4_luma;
    end

    assign n_prod = (42'(r5_v) << 8) - 42'(r5_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_spot.valid <= 1'b0;
        end else begin
            r6_spot.valid <= r5_valid;
        end
        r6_spot.spot <= r5_unknown ? 8'd255 : n_prod[40:33];
        r6_spot.luma <= r5_luma;
    end

    assign o_spot = r6_spot;

endmodule

// ===== sv/hss_ramp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hss_ramp
// Thresholds the luminance against the spot level through the grey ramp,
// dividing by the ramp width two quotient bits per stage.
// ----------------------------------------------------------------------------
module hss_ramp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hss_pkg::t_spot    i_spot,
    input  logic [7:0]        i_smoothing,
    output logic              o_valid,
    output hss_pkg::t_pix_out o_pix
);

    typedef struct packed {
        logic        neg;
        logic        over;
        logic [7:0]  width;
        logic [7:0]  spot;
        logic [15:0] rem;
        logic [7:0]  quo;
    } t_div;

    logic [7:0] n_width;
    logic [8:0] n_diff;
    logic [4:0] r_dv;
    t_div       r_dp [5];
    t_div       n_dp [4];

    logic              r_out_valid;
    hss_pkg::t_pix_out r_out;

    always_comb begin
        n_width = (i_smoothing == 8'd0) ? 8'd1 : i_smoothing;
        n_diff  = {1'b0, i_spot.luma} - {1'b0, i_spot.spot};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= i_spot.valid;
        end
        r_dp[0].neg   <= n_diff[8];
        r_dp[0].over  <= !n_diff[8] && (n_diff[7:0] > n_width);
        r_dp[0].width <= n_width;
        r_dp[0].spot  <= i_spot.spot;
        r_dp[0].rem   <= (16'(n_diff[7:0]) << 8) - 16'(n_diff[7:0]);
        r_dp[0].quo   <= 8'd0;
    end

    for (genvar k = 0; k < 4; k++) begin : g_div
        always_comb begin
            logic [15:0] cand;
            n_dp[k] = r_dp[k];
            for (int b = 1; b >= 0; b--) begin
                cand = 16'(r_dp[k].width) << (7 - 2 * k - (1 - b));
                if (n_dp[k].rem >= cand) begin
                    n_dp[k].rem = n_dp[k].rem - cand;
                    n_dp[k].quo[7 - 2 * k - (1 - b)] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k + 1] <= 1'b0;
            end else begin
                r_dv[k + 1] <= r_dv[k];
            end
            r_dp[k + 1] <= n_dp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_dv[4];
        end
        r_out.spot_level <= r_dp[4].spot;
        if (r_dp[4].neg) begin
            r_out.grey_level <= 8'd0;
        end else if (r_dp[4].over) begin
            r_out.grey_level <= 8'd255;
        end else begin
            r_out.grey_level <= r_dp[4].quo;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out;

endmodule

// ===== sv/halftone_spot_screen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halftone_spot_screen
// Halftone spot-function screening of one texel per clock: normalisation,
// spot function evaluation and grey ramp thresholding.
// ----------------------------------------------------------------------------
// Throughput is one transfer per cycle; busy is never raised.
// The pipeline depth is set by the reciprocal normalisation, the spot
// multipliers and the four-stage ramp divider.
// Synchronous active-low reset clears the pipeline and loads the register
// defaults; the receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module halftone_spot_screen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  hss_pkg::t_pix_in  i_pix,
    output logic              o_done,
    output hss_pkg::t_pix_out o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data
);

    hss_pkg::t_cfg  r_cfg;
    hss_pkg::t_norm w_norm;
    hss_pkg::t_spot w_spot;
    logic [3:0]     r_run_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cell_size <= 6'd8;
            r_cfg.dot_style <= hss_pkg::STYLE_ROUND;
            r_cfg.smoothing <= 8'd128;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hss_pkg::REG_CELL_SIZE: r_cfg.cell_size <= i_cfg_data[5:0];
                hss_pkg::REG_DOT_STYLE: r_cfg.dot_style <= i_cfg_data[2:0];
                hss_pkg::REG_SMOOTHING: r_cfg.smoothing <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_busy = 1'b0;

    hss_normalize u_normalize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_pix   (i_pix),
        .i_cfg   (r_cfg),
        .o_norm  (w_norm)
    );

    hss_spot u_spot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_norm      (w_norm),
        .i_dot_style (r_cfg.dot_style),
        .o_spot      (w_spot)
    );

    hss_ramp u_ramp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spot      (w_spot),
        .i_smoothing (r_cfg.smoothing),
        .o_valid     (o_done),
        .o_pix       (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= 4'd0;
        end else if (r_run_cnt != 4'(hss_pkg::PIPE_LATENCY)) begin
            r_run_cnt <= r_run_cnt + 4'd1;
        end
    end

    a_transfer_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_cnt == 4'(hss_pkg::PIPE_LATENCY)) && $past(i_start, hss_pkg::PIPE_LATENCY)
        |-> o_done)
        else $error("Accepted transfer produced no result after the pipeline latency.");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, hss_pkg::PIPE_LATENCY))
        else $error("Result strobe without a matching start transfer.");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the halftone spot screen. It drives directed and
// random texels under several register settings and compares each result
// with a predictor of the spot functions and the grey ramp.
// ----------------------------------------------------------------------------

class screen_scoreboard;
    hss_pkg::t_pix_out pending[$];
    int       n_errors;
    int       n_checked;
    logic [5:0] cfg_size;
    logic [2:0] cfg_style;
    logic [7:0] cfg_smooth;

    function new();
        n_errors  = 0;
        n_checked = 0;
        cfg_size  = 6'd8;
        cfg_style = hss_pkg::STYLE_ROUND;
        cfg_smooth = 8'd128;
    endfunction

    function longint norm_coord(longint p, longint n);
        return ((p - n / 2) * 131072) / n;
    endfunction

    function longint to_level(longint v, int shift);
        longint r;
        if (v <= 0) return 0;
        r = (v * 255) >>> shift;
        return (r > 255) ? 255 : r;
    endfunction

    function hss_pkg::t_pix_out screen_pixel(hss_pkg::t_pix_in px);
        longint n, c, r, ax, ay, s, spot, diff, wid, grey, rnd, outer;
        hss_pkg::t_pix_out o;
        n = cfg_size;
        if (n < 1) n = 1;
        if (n > hss_pkg::MAX_CELL) n = hss_pkg::MAX_CELL;
        c = px.cell_col;
        r = px.cell_row;
        if (c >= n) c = n - 1;
        if (r >= n) r = n - 1;
        ax = norm_coord(c, n);
        ay = norm_coord(r, n);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        s = ax + ay;
        rnd = (longint'(2) << 32) - (ax * ax + ay * ay);
        outer = (ax - 65536) * (ax - 65536) + (ay - 65536) * (ay - 65536);
        case (cfg_style)
            hss_pkg::STYLE_ROUND:     spot = to_level(rnd, 33);
            hss_pkg::STYLE_LINE:      spot = to_level(65536 - ay, 16);
            hss_pkg::STYLE_DIAMOND:   spot = to_level(131072 - s, 17);
            hss_pkg::STYLE_EUCLIDEAN:
                spot = (s > 65536) ? to_level(outer, 33) : to_level(rnd, 33);
            hss_pkg::STYLE_PS: begin
                if (s <= hss_pkg::PS_INNER_Q16) spot = to_level(rnd, 33);
                else if (s <= hss_pkg::PS_MID_Q16)
                    spot = to_level((longint'(2) << 32) -
                                    (ay * hss_pkg::PS_SLOPE_Q16 + ax * 65536), 33);
                else spot = to_level(outer, 33);
            end
            default: spot = 255;
        endcase
        wid = (cfg_smooth == 0) ? 1 : cfg_smooth;
        diff = px.luma - spot;
        if (diff < 0) grey = 0;
        else if (diff > wid) grey = 255;
        else grey = (diff * 255) / wid;
        o.grey_level = grey[7:0];
        o.spot_level = spot[7:0];
        return o;
    endfunction

    function void note_input(hss_pkg::t_pix_in px);
        pending.push_back(screen_pixel(px));
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    task check_result(hss_pkg::t_pix_out got);
        hss_pkg::t_pix_out want;
        if (pending.size() == 0) begin
            report_mismatch("unexpected result, grey", got.grey_level, -1);
            return;
        end
        want = pending.pop_front();
        n_checked++;
        if (got.grey_level !== want.grey_level)
            report_mismatch("grey_level", got.grey_level, want.grey_level);
        if (got.spot_level !== want.spot_level)
            report_mismatch("spot_level", got.spot_level, want.spot_level);
    endtask
endclass

module tb_top;
    logic     i_clk;
    logic     i_rst_n;
    logic     i_start;
    logic     o_busy;
    hss_pkg::t_pix_in  i_pix;
    logic     o_done;
    hss_pkg::t_pix_out o_result;
    logic     i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    screen_scoreboard sb;
    longint cycle_count;
    int     n_sent;

    localparam longint CYCLE_LIMIT = 200000;

    halftone_spot_screen DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_pix(i_pix), .o_done(o_done), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_pix = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = hss_pkg::REG_CELL_SIZE;
        i_cfg_data = '0;
        cycle_count = 0;
        n_sent = 0;
        sb = new();
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("halftone_spot_screen: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result);
    end

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            hss_pkg::REG_CELL_SIZE: sb.cfg_size  = val[5:0];
            hss_pkg::REG_DOT_STYLE: sb.cfg_style = val[2:0];
            hss_pkg::REG_SMOOTHING: sb.cfg_smooth = val;
            default: ;
        endcase
    endtask

    task automatic send_pixel(hss_pkg::t_pix_in px);
        i_start <= 1'b1;
        i_pix   <= px;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_input(px);
        n_sent++;
    endtask

    task automatic pause_sender();
        i_start <= 1'b0;
        i_pix   <= hss_pkg::t_pix_in'($urandom);
        @(posedge i_clk);
    endtask

    task automatic drain_pipe();
        int guard;
        i_start <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (hss_pkg::PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_burst(int count);
        int left, burst;
        hss_pkg::t_pix_in px;
        logic [5:0] n;
        left = count;
        n = (sb.cfg_size == 0) ? 6'd1 : sb.cfg_size;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                px = hss_pkg::t_pix_in'($urandom);
                if ($urandom_range(0, 3) != 0 && n <= 32) begin
                    px.cell_col = 5'($urandom_range(0, n - 1));
                    px.cell_row = 5'($urandom_range(0, n - 1));
                end
                send_pixel(px);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 6)) pause_sender();
        end
    endtask

    initial begin
        hss_pkg::t_pix_in px;
        int k;
        logic [7:0] sizes[8];
        logic [7:0] smooths[6];
        sizes   = '{8'd1, 8'd32, 8'd0, 8'd63, 8'd2, 8'd7, 8'd16, 8'd33};
        smooths = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd17, 8'd64};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults, then the field extremes.
        foreach (sizes[j]) begin
            if (j >= 1) break;
        end
        for (k = 0; k < 20; k++) begin
            px.cell_col = (k & 1) ? 5'd31 : 5'd0;
            px.cell_row = (k & 2) ? 5'd31 : 5'd0;
            px.luma     = (k & 4) ? 8'd255 : ((k & 8) ? 8'd0 : 8'($urandom));
            if (k >= 16) begin
                px.cell_col = 5'd4;
                px.cell_row = 5'd4 - 5'(k - 16);
            end
            send_pixel(px);
        end
        drain_pipe();

        for (int ph = 0; ph < 24; ph++) begin
            write_reg(hss_pkg::REG_CELL_SIZE, sizes[ph % 8]);
            write_reg(hss_pkg::REG_DOT_STYLE, 8'(ph % 8));
            write_reg(hss_pkg::REG_SMOOTHING, smooths[ph % 6]);
            write_reg(2'd3, 8'($urandom));
            for (k = 0; k < 6; k++) begin
                px = hss_pkg::t_pix_in'($urandom);
                if (k < 2) px.luma = k ? 8'd255 : 8'd0;
                send_pixel(px);
            end
            random_burst(58);
            drain_pipe();
        end

        $display("Covered %0d pixels over cell sizes 0..63, all dot styles and", n_sent);
        $display("ramp widths from 0 to 255; %0d results checked.", sb.n_checked);
        if (sb.n_errors == 0 && sb.pending.size() == 0) begin
            $display("halftone_spot_screen: match");
        end else begin
            $display("halftone_spot_screen: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/hss_pkg.sv
sv/hss_normalize.sv
sv/hss_spot.sv
sv/hss_ramp.sv
sv/halftone_spot_screen.sv
tb/tb_top.sv
